>>> rtl/bpj_pkg.sv
package bpj_pkg;

    localparam int SLOT_W    = 21;
    localparam int REG_W     = 63;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 4;
    localparam int PIX_W     = 12;

    localparam int PROD_W  = 34;  // coefficient times pixel index
    localparam int NW      = 35;  // ray component, 19 fraction bits
    localparam int MW      = 57;  // R*n, 38 fraction bits
    localparam int MAG_W   = 55;  // |R*n|
    localparam int CT_W    = 42;  // one R*t product
    localparam int CX_W    = 44;  // -R*t sum
    localparam int BASE_W  = 32;
    localparam int UV_W    = 16;
    localparam int D2_W    = 64;
    localparam int DEPTH_W = 32;
    localparam int NZ_W    = 34;  // |n.z|
    localparam int PW      = 87;  // depth * |m|
    localparam int QW      = 48;  // quotient bits 61..14
    localparam int MLO_W   = 28;

    localparam int DEF_MAX_DIM    = 4096;
    localparam int DEF_COEF_WIDTH = 21;

    localparam int RAY_STAGES  = 4;
    localparam int SQRT_STAGES = 32;
    localparam int MUL_STAGES  = 2;
    localparam int DIV_STAGES  = QW;
    localparam int LATENCY     = RAY_STAGES + SQRT_STAGES + MUL_STAGES + DIV_STAGES + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_KINV0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KINV1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KINV2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT0  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT1  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT2  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GEOM  = 4'd7;

    typedef struct packed {
        logic [PIX_W-1:0] row;
        logic [PIX_W-1:0] col;
    } t_req;

    typedef struct packed {
        logic [PIX_W-1:0]  out_row;
        logic [PIX_W-1:0]  out_col;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic              invalid;
    } t_result;

    typedef struct packed {
        logic [2:0][REG_W-1:0] kinv;
        logic [2:0][REG_W-1:0] rot;
        logic [REG_W-1:0]      trans;
        logic [CFG_W-1:0]      geom;
    } t_cfg;

    // per-pixel values that ride along the depth pipeline
    typedef struct packed {
        logic [PIX_W-1:0]         row;
        logic [PIX_W-1:0]         col;
        logic signed [MW-1:0]     mx;
        logic signed [MW-1:0]     my;
        logic signed [NW-1:0]     nz;
        logic signed [BASE_W-1:0] bx;
        logic signed [BASE_W-1:0] by;
    } t_carry;

    // what the output stage still needs after the divider
    typedef struct packed {
        logic [PIX_W-1:0]         row;
        logic [PIX_W-1:0]         col;
        logic signed [BASE_W-1:0] bx;
        logic signed [BASE_W-1:0] by;
        logic                     nz_zero;
    } t_tail;

    // Q2.19 slot k, low (SLOT_W - cw) bits dropped
    function automatic logic signed [SLOT_W-1:0] coef(input logic [REG_W-1:0] r,
                                                      input int k, input int cw);
        logic [SLOT_W-1:0] raw;
        logic [SLOT_W-1:0] mask;
        raw  = r[k*SLOT_W +: SLOT_W];
        mask = {SLOT_W{1'b1}} << (SLOT_W - cw);
        return $signed(raw & mask);
    endfunction

    function automatic logic signed [SLOT_W-1:0] tslot(input logic [REG_W-1:0] r,
                                                       input int k);
        return $signed(r[k*SLOT_W +: SLOT_W]);
    endfunction

endpackage

>>> rtl/pixel_ground_backprojection.sv
// Pixel to ground back-projection. Each request (row, col) is cast through
// the inverse intrinsics as a ray n, scaled by a depth taken from the image
// geometry (ground resolution, altitude, offset from the image center), turned
// by the rotation and moved by -R*t; x and y come back as saturated Q16.16
// meters with an invalid flag for a zero ray z or a saturated value. The block
// is a fixed pipeline that takes a request on every cycle: o_busy is never
// raised, and each result appears on o_result with o_done high for exactly one
// cycle, after its request has passed through 4 ray/matrix stages, 32 square
// root stages of one bit each, 2 multiply stages, 48 divider stages of one
// quotient bit each, and 1 output stage. Results come out in request order. The
// receiver cannot stall the block, so it must take every strobed result.
// Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_wdata
// and must only change while no request is in flight; indexes above 7 are
// ignored. All configuration registers reset to zero.
module pixel_ground_backprojection #(
    parameter int MAX_DIM    = bpj_pkg::DEF_MAX_DIM,
    parameter int COEF_WIDTH = bpj_pkg::DEF_COEF_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  bpj_pkg::t_req                    i_req,
    output logic                             o_busy,
    output logic                             o_done,
    output bpj_pkg::t_result                 o_result,
    input  logic                             i_cfg_we,
    input  logic [bpj_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bpj_pkg::CFG_W-1:0]        i_cfg_wdata
);

    // ---- configuration registers
    bpj_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bpj_pkg::CFG_KINV0: r_cfg.kinv[0] <= i_cfg_wdata[bpj_pkg::REG_W-1:0];
                bpj_pkg::CFG_KINV1: r_cfg.kinv[1] <= i_cfg_wdata[bpj_pkg::REG_W-1:0];
                bpj_pkg::CFG_KINV2: r_cfg.kinv[2] <= i_cfg_wdata[bpj_pkg::REG_W-1:0];
                bpj_pkg::CFG_ROT0:  r_cfg.rot[0]  <= i_cfg_wdata[bpj_pkg::REG_W-1:0];
                bpj_pkg::CFG_ROT1:  r_cfg.rot[1]  <= i_cfg_wdata[bpj_pkg::REG_W-1:0];
                bpj_pkg::CFG_ROT2:  r_cfg.rot[2]  <= i_cfg_wdata[bpj_pkg::REG_W-1:0];
                bpj_pkg::CFG_TRANS: r_cfg.trans   <= i_cfg_wdata[bpj_pkg::REG_W-1:0];
                bpj_pkg::CFG_GEOM:  r_cfg.geom    <= i_cfg_wdata;
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    // pipeline never backs up
    assign o_busy = 1'b0;

    // ---- ray, R*n, -R*t and depth squared
    logic                        ray_v;
    bpj_pkg::t_carry             ray_c;
    logic [bpj_pkg::D2_W-1:0]    ray_d2;

    bpj_ray #(
        .MAX_DIM    (MAX_DIM),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_ray (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (i_start),
        .i_req   (i_req),
        .i_cfg   (r_cfg),
        .o_v     (ray_v),
        .o_carry (ray_c),
        .o_d2    (ray_d2)
    );

    // ---- depth = floor(sqrt(d2)), 12 fraction bits
    logic                           sq_v;
    logic [bpj_pkg::DEPTH_W-1:0]    sq_depth;
    bpj_pkg::t_carry                sq_c;

    bpj_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (ray_v),
        .i_d2    (ray_d2),
        .i_carry (ray_c),
        .o_v     (sq_v),
        .o_depth (sq_depth),
        .o_carry (sq_c)
    );

    // ---- depth*|m| / |n.z|, quotient bits 61..14
    logic                       dv_v;
    logic [bpj_pkg::QW-1:0]     dv_q [2];
    logic                       dv_ovf [2];
    logic                       dv_neg [2];
    bpj_pkg::t_tail             dv_tail;

    bpj_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (sq_v),
        .i_depth (sq_depth),
        .i_carry (sq_c),
        .o_v     (dv_v),
        .o_q     (dv_q),
        .o_ovf   (dv_ovf),
        .o_neg   (dv_neg),
        .o_tail  (dv_tail)
    );

    // ---- output stage: round term, add base, saturate
    logic [bpj_pkg::QW-1:0]     term [2];
    logic signed [49:0]         sterm [2];
    logic signed [49:0]         sum [2];
    logic signed [49:0]         bsx [2];
    logic signed [31:0]         wv [2];
    logic                       sat [2];
    logic                       n_inv;

    always_comb begin
        bsx[0] = 50'(dv_tail.bx);
        bsx[1] = 50'(dv_tail.by);
        for (int k = 0; k < 2; k++) begin
            // (Q + 2^14) >> 15 from the bits above 13
            term[k]  = bpj_pkg::QW'((49'(dv_q[k]) + 49'(1)) >> 1);
            sterm[k] = dv_neg[k] ? -$signed(50'(term[k])) : $signed(50'(term[k]));
            sum[k]   = bsx[k] + sterm[k];
            sat[k]   = 1'b0;
            if (dv_tail.nz_zero) begin
                wv[k] = '0;
            end else if (dv_ovf[k]) begin
                wv[k]  = dv_neg[k] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                sat[k] = 1'b1;
            end else if (sum[k] > 50'sd2147483647) begin
                wv[k]  = 32'sh7FFF_FFFF;
                sat[k] = 1'b1;
            end else if (sum[k] < -50'sd2147483648) begin
                wv[k]  = 32'sh8000_0000;
                sat[k] = 1'b1;
            end else begin
                wv[k] = sum[k][31:0];
            end
        end
        n_inv = dv_tail.nz_zero | sat[0] | sat[1];
    end

    logic               r_done;
    bpj_pkg::t_result   r_result;

    always_ff @(posedge i_clk) begin
        r_result.out_row <= dv_tail.row;
        r_result.out_col <= dv_tail.col;
        r_result.world_x <= wv[0];
        r_result.world_y <= wv[1];
        r_result.invalid <= n_inv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= dv_v;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // every request comes out after the fixed latency, and nothing else does
    a_req_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##(bpj_pkg::LATENCY) o_done)
        else $error("request did not produce a result on time");

    a_done_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, bpj_pkg::LATENCY))
        else $error("result without a matching request");

endmodule

>>> rtl/bpj_ray.sv
module bpj_ray #(
    parameter int MAX_DIM    = bpj_pkg::DEF_MAX_DIM,
    parameter int COEF_WIDTH = bpj_pkg::DEF_COEF_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_v,
    input  bpj_pkg::t_req             i_req,
    input  bpj_pkg::t_cfg             i_cfg,
    output logic                      o_v,
    output bpj_pkg::t_carry           o_carry,
    output logic [bpj_pkg::D2_W-1:0]  o_d2
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    // ---- stage 1: pixel products, centre offsets
    logic                                 r1_vld;
    logic [bpj_pkg::PIX_W-1:0]            r1_row, r1_col;
    logic signed [bpj_pkg::PROD_W-1:0]    r1_pa [3];
    logic signed [bpj_pkg::PROD_W-1:0]    r1_pb [3];
    logic [bpj_pkg::UV_W-1:0]             r1_du, r1_dv;

    logic [DIM_W-1:0]                     rows_c, cols_c, half_r, half_c;
    logic signed [17:0]                   du, dv;
    logic signed [bpj_pkg::PROD_W-1:0]    rowx, colx;
    logic signed [bpj_pkg::PROD_W-1:0]    ka [3];
    logic signed [bpj_pkg::PROD_W-1:0]    kb [3];

    always_comb begin
        rows_c = ({1'b0, i_cfg.geom[47:32]} > 17'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                             : DIM_W'(i_cfg.geom[47:32]);
        cols_c = ({1'b0, i_cfg.geom[63:48]} > 17'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                             : DIM_W'(i_cfg.geom[63:48]);
        half_r = rows_c >> 1;
        half_c = cols_c >> 1;
        du     = $signed(18'(half_r)) - $signed(18'(i_req.row));
        dv     = $signed(18'(half_c)) - $signed(18'(i_req.col));
        rowx   = $signed(bpj_pkg::PROD_W'(i_req.row));
        colx   = $signed(bpj_pkg::PROD_W'(i_req.col));
        for (int k = 0; k < 3; k++) begin
            ka[k] = bpj_pkg::PROD_W'(bpj_pkg::coef(i_cfg.kinv[k], 0, COEF_WIDTH));
            kb[k] = bpj_pkg::PROD_W'(bpj_pkg::coef(i_cfg.kinv[k], 1, COEF_WIDTH));
        end
    end

    always_ff @(posedge i_clk) begin
        r1_row <= i_req.row;
        r1_col <= i_req.col;
        r1_du  <= du[17] ? bpj_pkg::UV_W'(-du) : bpj_pkg::UV_W'(du);
        r1_dv  <= dv[17] ? bpj_pkg::UV_W'(-dv) : bpj_pkg::UV_W'(dv);
        for (int k = 0; k < 3; k++) begin
            r1_pa[k] <= ka[k] * rowx;
            r1_pb[k] <= kb[k] * colx;
        end
    end

    // ---- stage 2: ray n, squares, R*t products
    logic                                 r2_vld;
    logic [bpj_pkg::PIX_W-1:0]            r2_row, r2_col;
    logic signed [bpj_pkg::NW-1:0]        r2_n [3];
    logic [31:0]                          r2_uu, r2_vv, r2_res2, r2_alt2;
    logic signed [bpj_pkg::CT_W-1:0]      r2_ct [2][3];

    logic signed [bpj_pkg::NW-1:0]        sa [3];
    logic signed [bpj_pkg::NW-1:0]        sb [3];
    logic signed [bpj_pkg::NW-1:0]        sc [3];
    logic signed [bpj_pkg::CT_W-1:0]      rc [2][3];
    logic signed [bpj_pkg::CT_W-1:0]      tc [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sa[k] = bpj_pkg::NW'(r1_pa[k]);
            sb[k] = bpj_pkg::NW'(r1_pb[k]);
            sc[k] = bpj_pkg::NW'(bpj_pkg::coef(i_cfg.kinv[k], 2, COEF_WIDTH));
            tc[k] = bpj_pkg::CT_W'(bpj_pkg::tslot(i_cfg.trans, k));
        end
        for (int k = 0; k < 2; k++) begin
            for (int j = 0; j < 3; j++) begin
                rc[k][j] = bpj_pkg::CT_W'(bpj_pkg::coef(i_cfg.rot[k], j, COEF_WIDTH));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r2_row  <= r1_row;
        r2_col  <= r1_col;
        r2_uu   <= 32'(r1_du) * 32'(r1_du);
        r2_vv   <= 32'(r1_dv) * 32'(r1_dv);
        r2_res2 <= 32'(i_cfg.geom[31:16]) * 32'(i_cfg.geom[31:16]);
        r2_alt2 <= 32'(i_cfg.geom[15:0]) * 32'(i_cfg.geom[15:0]);
        for (int k = 0; k < 3; k++) begin
            r2_n[k] <= sa[k] + sb[k] + sc[k];
        end
        for (int k = 0; k < 2; k++) begin
            for (int j = 0; j < 3; j++) begin
                r2_ct[k][j] <= rc[k][j] * tc[j];
            end
        end
    end

    // ---- stage 3: R*n products, -R*t sums, u^2+v^2
    logic                                 r3_vld;
    logic [bpj_pkg::PIX_W-1:0]            r3_row, r3_col;
    logic signed [bpj_pkg::MW-1:0]        r3_mp [2][3];
    logic signed [bpj_pkg::NW-1:0]        r3_nz;
    logic [32:0]                          r3_uv;
    logic [31:0]                          r3_res2, r3_alt2;
    logic signed [bpj_pkg::CX_W-1:0]      r3_cx [2];

    logic signed [bpj_pkg::MW-1:0]        rm [2][3];
    logic signed [bpj_pkg::MW-1:0]        nm [3];
    logic signed [bpj_pkg::CX_W-1:0]      ce [2][3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            nm[j] = bpj_pkg::MW'(r2_n[j]);
        end
        for (int k = 0; k < 2; k++) begin
            for (int j = 0; j < 3; j++) begin
                rm[k][j] = bpj_pkg::MW'(bpj_pkg::coef(i_cfg.rot[k], j, COEF_WIDTH));
                ce[k][j] = bpj_pkg::CX_W'(r2_ct[k][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r3_row  <= r2_row;
        r3_col  <= r2_col;
        r3_nz   <= r2_n[2];
        r3_uv   <= 33'(r2_uu) + 33'(r2_vv);
        r3_res2 <= r2_res2;
        r3_alt2 <= r2_alt2;
        for (int k = 0; k < 2; k++) begin
            r3_cx[k] <= -(ce[k][0] + ce[k][1] + ce[k][2]);
            for (int j = 0; j < 3; j++) begin
                r3_mp[k][j] <= rm[k][j] * nm[j];
            end
        end
    end

    // ---- stage 4: m sums, depth squared, rounded base
    logic                                 r4_vld;
    logic [bpj_pkg::PIX_W-1:0]            r4_row, r4_col;
    logic signed [bpj_pkg::MW-1:0]        r4_m [2];
    logic signed [bpj_pkg::NW-1:0]        r4_nz;
    logic signed [bpj_pkg::BASE_W-1:0]    r4_base [2];
    logic [bpj_pkg::D2_W-1:0]             r4_d2;

    logic [bpj_pkg::CX_W-1:0]             cmag [2];
    logic [bpj_pkg::CX_W-1:0]             crnd [2];
    logic signed [bpj_pkg::BASE_W-1:0]    cb [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            cmag[k] = r3_cx[k][bpj_pkg::CX_W-1] ? bpj_pkg::CX_W'(-r3_cx[k])
                                                : bpj_pkg::CX_W'(r3_cx[k]);
            crnd[k] = (cmag[k] + bpj_pkg::CX_W'(2048)) >> 12;
            cb[k]   = r3_cx[k][bpj_pkg::CX_W-1] ? -$signed(crnd[k][bpj_pkg::BASE_W-1:0])
                                                : $signed(crnd[k][bpj_pkg::BASE_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r4_row <= r3_row;
        r4_col <= r3_col;
        r4_nz  <= r3_nz;
        r4_d2  <= (64'(r3_uv) * 64'(r3_res2)) + (64'(r3_alt2) << 12);
        for (int k = 0; k < 2; k++) begin
            r4_m[k]    <= r3_mp[k][0] + r3_mp[k][1] + r3_mp[k][2];
            r4_base[k] <= cb[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= i_v;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    assign o_v           = r4_vld;
    assign o_d2          = r4_d2;
    assign o_carry.row   = r4_row;
    assign o_carry.col   = r4_col;
    assign o_carry.mx    = r4_m[0];
    assign o_carry.my    = r4_m[1];
    assign o_carry.nz    = r4_nz;
    assign o_carry.bx    = r4_base[0];
    assign o_carry.by    = r4_base[1];

endmodule

>>> rtl/bpj_sqrt.sv
module bpj_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_v,
    input  logic [bpj_pkg::D2_W-1:0]     i_d2,
    input  bpj_pkg::t_carry              i_carry,
    output logic                         o_v,
    output logic [bpj_pkg::DEPTH_W-1:0]  o_depth,
    output bpj_pkg::t_carry              o_carry
);

    localparam int NS = bpj_pkg::SQRT_STAGES;

    // one result bit per stage, bit weight 4^(31-s)
    logic                          r_v [NS];
    logic [bpj_pkg::D2_W-1:0]      r_x [NS];
    logic [bpj_pkg::D2_W-1:0]      r_r [NS];
    bpj_pkg::t_carry               r_c [NS];

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic                      v_in;
        logic [bpj_pkg::D2_W-1:0]  x_in, r_in, bitv, trial;
        bpj_pkg::t_carry           c_in;

        if (s == 0) begin : g_first
            assign v_in = i_v;
            assign x_in = i_d2;
            assign r_in = '0;
            assign c_in = i_carry;
        end else begin : g_next
            assign v_in = r_v[s-1];
            assign x_in = r_x[s-1];
            assign r_in = r_r[s-1];
            assign c_in = r_c[s-1];
        end

        assign bitv  = bpj_pkg::D2_W'(1) << (2 * (NS - 1 - s));
        assign trial = r_in + bitv;

        always_ff @(posedge i_clk) begin
            r_c[s] <= c_in;
            if (x_in >= trial) begin
                r_x[s] <= x_in - trial;
                r_r[s] <= (r_in >> 1) + bitv;
            end else begin
                r_x[s] <= x_in;
                r_r[s] <= r_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= v_in;
            end
        end
    end

    assign o_v     = r_v[NS-1];
    assign o_depth = r_r[NS-1][bpj_pkg::DEPTH_W-1:0];
    assign o_carry = r_c[NS-1];

endmodule

>>> rtl/bpj_div.sv
module bpj_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_v,
    input  logic [bpj_pkg::DEPTH_W-1:0]  i_depth,
    input  bpj_pkg::t_carry              i_carry,
    output logic                         o_v,
    output logic [bpj_pkg::QW-1:0]       o_q [2],
    output logic                         o_ovf [2],
    output logic                         o_neg [2],
    output bpj_pkg::t_tail               o_tail
);

    localparam int ND    = bpj_pkg::DIV_STAGES;
    localparam int HI_W  = bpj_pkg::MAG_W - bpj_pkg::MLO_W;
    localparam int PLO_W = bpj_pkg::DEPTH_W + bpj_pkg::MLO_W;
    localparam int PHI_W = bpj_pkg::DEPTH_W + HI_W;

    // ---- M1: split product depth * |m|
    logic                           r1_v;
    logic [PLO_W-1:0]               r1_plo [2];
    logic [PHI_W-1:0]               r1_phi [2];
    logic                           r1_neg [2];
    logic [bpj_pkg::NZ_W-1:0]       r1_nzm;
    bpj_pkg::t_tail                 r1_tail;

    logic signed [bpj_pkg::MW-1:0]  m_in [2];
    logic [bpj_pkg::MAG_W-1:0]      mmag [2];
    logic                           nzn;

    always_comb begin
        m_in[0] = i_carry.mx;
        m_in[1] = i_carry.my;
        nzn     = i_carry.nz[bpj_pkg::NW-1];
        for (int k = 0; k < 2; k++) begin
            mmag[k] = m_in[k][bpj_pkg::MW-1] ? bpj_pkg::MAG_W'(-m_in[k])
                                             : bpj_pkg::MAG_W'(m_in[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r1_nzm          <= nzn ? bpj_pkg::NZ_W'(-i_carry.nz) : bpj_pkg::NZ_W'(i_carry.nz);
        r1_tail.row     <= i_carry.row;
        r1_tail.col     <= i_carry.col;
        r1_tail.bx      <= i_carry.bx;
        r1_tail.by      <= i_carry.by;
        r1_tail.nz_zero <= (i_carry.nz == '0);
        for (int k = 0; k < 2; k++) begin
            r1_plo[k] <= PLO_W'(i_depth) * PLO_W'(mmag[k][bpj_pkg::MLO_W-1:0]);
            r1_phi[k] <= PHI_W'(i_depth) * PHI_W'(mmag[k][bpj_pkg::MAG_W-1:bpj_pkg::MLO_W]);
            r1_neg[k] <= m_in[k][bpj_pkg::MW-1] != nzn;
        end
    end

    // ---- M2: full product, overflow test, divider seed
    logic                           r2_v;
    logic [bpj_pkg::NZ_W-1:0]       r2_rem [2];
    logic [bpj_pkg::QW-1:0]         r2_low [2];
    logic                           r2_ovf [2];
    logic                           r2_neg [2];
    logic [bpj_pkg::NZ_W-1:0]       r2_nzm;
    bpj_pkg::t_tail                 r2_tail;

    logic [bpj_pkg::PW-1:0]         prod [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            prod[k] = (bpj_pkg::PW'(r1_phi[k]) << bpj_pkg::MLO_W) + bpj_pkg::PW'(r1_plo[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r2_nzm  <= r1_nzm;
        r2_tail <= r1_tail;
        for (int k = 0; k < 2; k++) begin
            // quotient >= 2^62 exactly when the top bits alone reach the divisor
            r2_ovf[k] <= bpj_pkg::NZ_W'(prod[k][bpj_pkg::PW-1:62]) >= r1_nzm;
            r2_rem[k] <= bpj_pkg::NZ_W'(prod[k][bpj_pkg::PW-1:62]);
            r2_low[k] <= prod[k][61:14];
            r2_neg[k] <= r1_neg[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            r1_v <= i_v;
            r2_v <= r1_v;
        end
    end

    // ---- restoring division, one quotient bit per stage
    logic                           r_v    [ND];
    logic [bpj_pkg::NZ_W-1:0]       r_rem  [ND][2];
    logic [bpj_pkg::QW-1:0]         r_low  [ND][2];
    logic [bpj_pkg::QW-1:0]         r_q    [ND][2];
    logic                           r_ovf  [ND][2];
    logic                           r_neg  [ND][2];
    logic [bpj_pkg::NZ_W-1:0]       r_nzm  [ND];
    bpj_pkg::t_tail                 r_tail [ND];

    for (genvar s = 0; s < ND; s++) begin : g_st
        logic                       v_in;
        logic [bpj_pkg::NZ_W-1:0]   rem_in [2];
        logic [bpj_pkg::QW-1:0]     low_in [2];
        logic [bpj_pkg::QW-1:0]     q_in   [2];
        logic                       ovf_in [2];
        logic                       neg_in [2];
        logic [bpj_pkg::NZ_W-1:0]   nzm_in;
        bpj_pkg::t_tail             tail_in;
        logic [bpj_pkg::NZ_W:0]     t [2];
        logic                       ge [2];

        if (s == 0) begin : g_first
            assign v_in    = r2_v;
            assign nzm_in  = r2_nzm;
            assign tail_in = r2_tail;
            for (genvar k = 0; k < 2; k++) begin : g_ln
                assign rem_in[k] = r2_rem[k];
                assign low_in[k] = r2_low[k];
                assign q_in[k]   = '0;
                assign ovf_in[k] = r2_ovf[k];
                assign neg_in[k] = r2_neg[k];
            end
        end else begin : g_next
            assign v_in    = r_v[s-1];
            assign nzm_in  = r_nzm[s-1];
            assign tail_in = r_tail[s-1];
            for (genvar k = 0; k < 2; k++) begin : g_ln
                assign rem_in[k] = r_rem[s-1][k];
                assign low_in[k] = r_low[s-1][k];
                assign q_in[k]   = r_q[s-1][k];
                assign ovf_in[k] = r_ovf[s-1][k];
                assign neg_in[k] = r_neg[s-1][k];
            end
        end

        for (genvar k = 0; k < 2; k++) begin : g_lane
            assign t[k]  = {rem_in[k], low_in[k][bpj_pkg::QW-1]};
            assign ge[k] = t[k] >= {1'b0, nzm_in};

            always_ff @(posedge i_clk) begin
                r_rem[s][k] <= ge[k] ? bpj_pkg::NZ_W'(t[k] - {1'b0, nzm_in})
                                     : bpj_pkg::NZ_W'(t[k]);
                r_low[s][k] <= low_in[k] << 1;
                r_q[s][k]   <= {q_in[k][bpj_pkg::QW-2:0], ge[k]};
                r_ovf[s][k] <= ovf_in[k];
                r_neg[s][k] <= neg_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_nzm[s]  <= nzm_in;
            r_tail[s] <= tail_in;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= v_in;
            end
        end
    end

    assign o_v    = r_v[ND-1];
    assign o_tail = r_tail[ND-1];
    for (genvar k = 0; k < 2; k++) begin : g_out
        assign o_q[k]   = r_q[ND-1][k];
        assign o_ovf[k] = r_ovf[ND-1][k];
        assign o_neg[k] = r_neg[ND-1][k];
    end

    // a finished in-range division leaves a remainder below the divisor
    a_rem_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[ND-1] && !r_tail[ND-1].nz_zero && !r_ovf[ND-1][0])
            |-> (r_rem[ND-1][0] < r_nzm[ND-1]))
        else $error("divider x remainder not below divisor");

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpj_pkg::*;

    // Coefficient width used by the instance below; the predictor masks the same way.
    localparam int TB_COEF_W    = DEF_COEF_WIDTH;
    localparam int TB_MAX_DIM   = DEF_MAX_DIM;
    localparam int WDOG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = LATENCY + 16;
    localparam int Q20_ONE      = 1 << 19;    // 1.0 in Q2.19

    // Camera kinds used across the configuration phases.
    typedef enum int {
        CAM_ZERO,       // all coefficients zero: every ray z is zero
        CAM_PINHOLE,    // plausible intrinsics, identity rotation
        CAM_EXTREME,    // coefficients and geometry at their extremes
        CAM_RANDOM,     // every register random
        CAM_TILTED      // ray z crosses zero inside the image
    } t_cam;

    // ------------------------------------------------------------------
    // Ground-position predictor and in-order store of expected results
    // ------------------------------------------------------------------
    class ground_scoreboard;
        logic [CFG_W-1:0] cfg_regs [8];
        t_result          pending [$];
        int               errors;

        function new();
            foreach (cfg_regs[i]) cfg_regs[i] = '0;
            errors = 0;
        endfunction

        function void note_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx > CFG_GEOM) return;
            cfg_regs[idx] = (idx == CFG_GEOM) ? val : {1'b0, val[REG_W-1:0]};
        endfunction

        function longint slot(logic [CFG_W-1:0] r, int k, bit is_coef);
            logic [SLOT_W-1:0] raw;
            raw = r[k*SLOT_W +: SLOT_W];
            if (is_coef) raw = raw & ({SLOT_W{1'b1}} << (SLOT_W - TB_COEF_W));
            return longint'($signed(raw));
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] x);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // magnitude rounded half away from zero, 12 bits dropped
        function longint round12(longint v);
            if (v >= 0) return (v + 2048) >>> 12;
            return -((-v + 2048) >>> 12);
        endfunction

        function void note_request(t_req rq);
            t_result     e;
            longint      n [3];
            longint      m [3];
            longint      mt [3];
            longint      rows, cols, u, v, mag, base, term, sum;
            longint      nz_abs;
            logic [63:0] d2, depth;
            logic [127:0] prod, quot;
            bit          neg;

            rows = cfg_regs[CFG_GEOM][47:32];
            cols = cfg_regs[CFG_GEOM][63:48];
            if (rows > TB_MAX_DIM) rows = TB_MAX_DIM;
            if (cols > TB_MAX_DIM) cols = TB_MAX_DIM;

            for (int k = 0; k < 3; k++)
                n[k] = slot(cfg_regs[k], 0, 1) * longint'(rq.row)
                     + slot(cfg_regs[k], 1, 1) * longint'(rq.col)
                     + slot(cfg_regs[k], 2, 1);
            for (int k = 0; k < 3; k++) begin
                m[k]  = 0;
                mt[k] = 0;
                for (int j = 0; j < 3; j++) begin
                    m[k]  += slot(cfg_regs[3+k], j, 1) * n[j];
                    mt[k] -= slot(cfg_regs[3+k], j, 1) * slot(cfg_regs[CFG_TRANS], j, 0);
                end
            end

            e.out_row = rq.row;
            e.out_col = rq.col;
            e.world_x = '0;
            e.world_y = '0;
            e.invalid = 1'b0;

            if (n[2] == 0) begin
                e.invalid = 1'b1;
            end else begin
                u = rows / 2 - longint'(rq.row);
                v = cols / 2 - longint'(rq.col);
                if (u < 0) u = -u;
                if (v < 0) v = -v;
                d2 = 64'(u*u + v*v) * (64'(cfg_regs[CFG_GEOM][31:16])
                                        * 64'(cfg_regs[CFG_GEOM][31:16]))
                   + ((64'(cfg_regs[CFG_GEOM][15:0]) * 64'(cfg_regs[CFG_GEOM][15:0])) << 12);
                depth  = int_sqrt(d2);
                nz_abs = (n[2] < 0) ? -n[2] : n[2];
                for (int k = 0; k < 2; k++) begin
                    neg  = (m[k] < 0) != (n[2] < 0);
                    mag  = (m[k] < 0) ? -m[k] : m[k];
                    base = round12(mt[k]);
                    prod = 128'(depth) * 128'(mag);
                    quot = prod / 128'(nz_abs);
                    if (quot >= (128'd1 << 62)) begin
                        sum = neg ? -64'sd2147483648 : 64'sd2147483647;
                        e.invalid = 1'b1;
                    end else begin
                        term = longint'((quot[63:0] + 64'd16384) >> 15);
                        if (neg) term = -term;
                        sum = base + term;
                        if (sum > 64'sd2147483647) begin
                            sum = 64'sd2147483647;
                            e.invalid = 1'b1;
                        end else if (sum < -64'sd2147483648) begin
                            sum = -64'sd2147483648;
                            e.invalid = 1'b1;
                        end
                    end
                    if (k == 0) e.world_x = sum[31:0];
                    else        e.world_y = sum[31:0];
                end
            end
            pending.push_back(e);
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (pending.size() == 0) begin
                $error("result with nothing expected: row %0d col %0d",
                       got.out_row, got.out_col);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.out_row !== e.out_row) begin
                $error("out_row: expected %0d, got %0d", e.out_row, got.out_row); errors++;
            end
            if (got.out_col !== e.out_col) begin
                $error("out_col: expected %0d, got %0d", e.out_col, got.out_col); errors++;
            end
            if (got.world_x !== e.world_x) begin
                $error("world_x: expected %0d, got %0d", e.world_x, got.world_x); errors++;
            end
            if (got.world_y !== e.world_y) begin
                $error("world_y: expected %0d, got %0d", e.world_y, got.world_y); errors++;
            end
            if (got.invalid !== e.invalid) begin
                $error("invalid: expected %0b, got %0b", e.invalid, got.invalid); errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    t_req                 req = '0;
    logic                 busy;
    logic                 done;
    t_result              result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    ground_scoreboard sb = new();
    int idle_cycles = 0;

    always #4 clk = ~clk;

    pixel_ground_backprojection #(
        .MAX_DIM    (TB_MAX_DIM),
        .COEF_WIDTH (TB_COEF_W)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .i_req       (req),
        .o_busy      (busy),
        .o_done      (done),
        .o_result    (result),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // Monitor: requests and results are taken on the same edge the block takes
    // them, so the values seen here are the ones from before the edge.
    // The watchdog counts edges where neither side moves anything.
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) sb.note_request(req);
            if (done) sb.check_result(result);
            if ((start && !busy) || done) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles + 1 >= WDOG_LIMIT) begin
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic logic [CFG_W-1:0] pack_row(int a, int b, int c);
        logic [CFG_W-1:0] r;
        r = '0;
        r[0 +: SLOT_W]        = a[SLOT_W-1:0];
        r[SLOT_W +: SLOT_W]   = b[SLOT_W-1:0];
        r[2*SLOT_W +: SLOT_W] = c[SLOT_W-1:0];
        r[CFG_W-1] = 1'($urandom_range(0, 1));   // unused top bit, toggled on purpose
        return r;
    endfunction

    // write enable stays high across back-to-back writes; load_camera drops it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.note_cfg(idx, val);
    endtask

    // Short gaps mostly, a long one now and then, runs with no gaps at all.
    function automatic int pick_gap(bit burst);
        int p;
        if (burst) return 0;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_pixel(logic [PIX_W-1:0] row, logic [PIX_W-1:0] col, bit burst);
        int gap;
        start   <= 1'b1;
        req.row <= row;
        req.col <= col;
        @(posedge clk);
        while (busy) @(posedge clk);
        gap = pick_gap(burst);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Configuration is only touched with the pipeline empty.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_camera(t_cam cam);
        int s;
        logic [15:0] rows, cols;
        case (cam)
            CAM_ZERO: begin
                for (int i = 0; i < 8; i++) write_reg(CFG_IDX_W'(i), '0);
                write_reg(CFG_GEOM, {16'd640, 16'd480, 16'd4096, 16'd6400});
            end
            CAM_PINHOLE: begin
                s = $urandom_range(300, 700);     // roughly 1/f in Q2.19
                write_reg(CFG_KINV0, pack_row(s, 0, -Q20_ONE));
                write_reg(CFG_KINV1, pack_row(0, s, -Q20_ONE));
                write_reg(CFG_KINV2, pack_row(0, 0, Q20_ONE));
                write_reg(CFG_ROT0, pack_row(Q20_ONE - 1, 0, 0));
                write_reg(CFG_ROT1, pack_row(0, Q20_ONE - 1, 0));
                write_reg(CFG_ROT2, pack_row(0, 0, Q20_ONE - 1));
                write_reg(CFG_TRANS, pack_row($urandom_range(0, 40000) - 20000,
                                              $urandom_range(0, 40000) - 20000,
                                              $urandom_range(0, 60000)));
                rows = 16'($urandom_range(2, 4096));
                cols = 16'($urandom_range(2, 4096));
                write_reg(CFG_GEOM, {cols, rows, 16'($urandom_range(100, 2000)),
                                     16'($urandom_range(640, 20000))});
            end
            CAM_EXTREME: begin
                // most negative and most positive coefficients, all-ones geometry
                write_reg(CFG_KINV0, pack_row(-(1 << 20), (1 << 20) - 1, -(1 << 20)));
                write_reg(CFG_KINV1, pack_row((1 << 20) - 1, (1 << 20) - 1, (1 << 20) - 1));
                write_reg(CFG_KINV2, pack_row(1, 0, 1));
                write_reg(CFG_ROT0, pack_row(-(1 << 20), -(1 << 20), -(1 << 20)));
                write_reg(CFG_ROT1, pack_row((1 << 20) - 1, -(1 << 20), (1 << 20) - 1));
                write_reg(CFG_ROT2, pack_row(0, 0, 0));
                write_reg(CFG_TRANS, pack_row(-(1 << 20), (1 << 20) - 1, -(1 << 20)));
                write_reg(CFG_GEOM, '1);
            end
            CAM_TILTED: begin
                // n.z = a*row + b*col + c changes sign across the frame
                write_reg(CFG_KINV0, pack_row($urandom_range(200, 900), 0, -Q20_ONE));
                write_reg(CFG_KINV1, pack_row(0, $urandom_range(200, 900), -Q20_ONE));
                write_reg(CFG_KINV2, pack_row(256, 256, -(256 * 64)));
                write_reg(CFG_ROT0, pack_row(Q20_ONE / 2, -Q20_ONE / 2, 1000));
                write_reg(CFG_ROT1, pack_row(Q20_ONE / 2, Q20_ONE / 2, -1000));
                write_reg(CFG_ROT2, pack_row(0, 3000, Q20_ONE - 1));
                write_reg(CFG_TRANS, pack_row(1234, -4321, 51200));
                write_reg(CFG_GEOM, {16'd128, 16'd128, 16'd300, 16'd6400});
            end
            default: begin
                for (int i = 0; i < 7; i++)
                    write_reg(CFG_IDX_W'(i), {$urandom(), $urandom()});
                write_reg(CFG_GEOM, {$urandom(), $urandom()});
            end
        endcase
        // indexes past the register list must be dropped
        write_reg(CFG_IDX_W'($urandom_range(8, 15)), {$urandom(), $urandom()});
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    t_cam plan [8] = '{CAM_PINHOLE, CAM_ZERO, CAM_EXTREME, CAM_TILTED,
                       CAM_RANDOM, CAM_PINHOLE, CAM_RANDOM, CAM_TILTED};

    initial begin
        logic [PIX_W-1:0] corner_r [12];
        logic [PIX_W-1:0] corner_c [12];
        int  run_left;
        bit  burst;

        corner_r = '{0, 4095, 0, 4095, 2048, 1024, 1, 4094, 2047, 0, 4095, 64};
        corner_c = '{0, 4095, 4095, 0, 2048, 4095, 1, 4094, 2049, 64, 2048, 0};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: the frame corners and center under a normal camera,
        // then the same pixels with zero ray z and with saturating terms.
        foreach (plan[p]) begin
            load_camera(plan[p]);
            if (p < 3) begin
                foreach (corner_r[i]) send_pixel(corner_r[i], corner_c[i], 1'b0);
            end
            run_left = 0;
            burst    = 1'b0;
            for (int i = 0; i < 80; i++) begin
                if (run_left == 0) begin
                    burst    = ($urandom_range(0, 3) == 0);
                    run_left = $urandom_range(4, 20);
                end
                run_left--;
                // mostly pixels with a row below 2048, some anywhere
                if ($urandom_range(0, 3) == 0)
                    send_pixel(PIX_W'($urandom()), PIX_W'($urandom()), burst);
                else
                    send_pixel(PIX_W'($urandom_range(0, 2047)),
                               PIX_W'($urandom_range(0, 4095)), burst);
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
